// ===== src/swm_pkg.sv =====
// Shared constants, types and control codes for the sliding window maximum block.
`timescale 1ns / 1ps

package swm_pkg;

   // Number of candidate cells, which is also the largest window.
   localparam int CELLS = 64;
   // Positions wrap modulo twice the cell count.
   localparam int POS_W = $clog2(2 * CELLS);
   localparam int SAMPLE_W = 32;
   localparam int WLEN_W = 7;

   // Operation that the sequencer hands to every cell.
   typedef enum logic [1:0] {
      OP_HOLD,
      OP_ACCEPT,
      OP_DRAIN
   } op_type;

   // Contents of one candidate cell.
   typedef struct packed {
      logic                       valid;
      logic signed [SAMPLE_W-1:0] value;
      logic [POS_W-1:0]           position;
   } cell_type;

   // Control broadcast to all cells.
   typedef struct packed {
      op_type                     op;
      logic                       shift;
      logic                       start;
      logic signed [SAMPLE_W-1:0] sample;
      logic [POS_W-1:0]           pos;
      logic [POS_W-1:0]           win;
   } ctl_type;

   // Status that a cell reports to its neighbors and the sequencer.
   typedef struct packed {
      logic aged;
      logic surv;
      logic surv_sh;
   } stat_type;

endpackage

// ===== src/swm_cell.sv =====
// One candidate cell of the decreasing list: ages, compares and moves its entry.
`timescale 1ns / 1ps

module swm_cell (
   input  logic               clock,
   input  logic               reset,
   input  swm_pkg::ctl_type   ctl,
   input  swm_pkg::cell_type  nxt_data,
   input  logic               nxt_surv,
   input  logic               prv_surv_sh,
   output swm_pkg::cell_type  data,
   output swm_pkg::stat_type  stat
);

   logic                                valid_ff;
   logic                                valid_in;
   logic signed [swm_pkg::SAMPLE_W-1:0] value_ff;
   logic signed [swm_pkg::SAMPLE_W-1:0] value_in;
   logic [swm_pkg::POS_W-1:0]           position_ff;
   logic [swm_pkg::POS_W-1:0]           position_in;
   logic [swm_pkg::POS_W-1:0]           age;
   logic                                aged;
   logic                                kill;
   logic                                surv;
   logic                                surv_sh;

   // Age is taken modulo the position range; the subtract wraps by itself.
   assign age  = ctl.pos - position_ff;
   assign aged = valid_ff && (age >= ctl.win);
   assign kill = valid_ff && (value_ff < ctl.sample);
   assign surv = valid_ff && !aged && !kill && !ctl.start;

   // Survivor flag as it stands after an optional one-place front drop.
   assign surv_sh = ctl.shift ? nxt_surv : surv;

   assign data.valid    = valid_ff;
   assign data.value    = value_ff;
   assign data.position = position_ff;
   assign stat.aged     = aged;
   assign stat.surv     = surv;
   assign stat.surv_sh  = surv_sh;

   // Pick the next entry: keep, take the neighbor's, take the new sample, or empty.
   always_comb begin
      valid_in    = valid_ff;
      value_in    = value_ff;
      position_in = position_ff;
      unique case (ctl.op)
         swm_pkg::OP_DRAIN: begin
            valid_in    = nxt_data.valid;
            value_in    = nxt_data.value;
            position_in = nxt_data.position;
         end
         swm_pkg::OP_ACCEPT: begin
            if (surv_sh) begin
               valid_in = 1'b1;
               if (ctl.shift) begin
                  value_in    = nxt_data.value;
                  position_in = nxt_data.position;
               end
            end else if (prv_surv_sh) begin
               valid_in    = 1'b1;
               value_in    = ctl.sample;
               position_in = ctl.pos;
            end else begin
               valid_in = 1'b0;
            end
         end
         default: begin
            valid_in = valid_ff;
         end
      endcase
   end

   // Hold the occupancy flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Hold the payload.
   always_ff @(posedge clock) begin
      value_ff    <= value_in;
      position_ff <= position_in;
   end

endmodule

// ===== src/sliding_window_maximum.sv =====
// Top level of the sliding window maximum: sequencer, cell chain and output register.
//
// Use: samples arrive on the req_ channel (req_valid, req_stall, req_sample,
// req_start_req). An item is taken at a clock edge with req_valid high and
// req_stall low. req_start_req empties the candidate list and restarts the
// position count before its own sample is taken in. Once window_length samples
// of the sequence have been seen, each item yields one window_max on the rsp_
// channel (rsp_valid, rsp_stall, rsp_window_max); earlier items yield nothing.
// The window length is written on the csr_ channel (csr_valid, csr_ready,
// csr_window_length), which is always ready; write it only while idle.
// The result is registered and appears in the cycle after its item is taken.
// Throughput: one item per cycle unless stalled. After the window length is lowered in a
// sequence, each candidate beyond the first that has left the window stalls the
// next item while it is drained, since the cell chain drops one front entry per cycle.
// The output register holds a result while rsp_stall is high; the next item is
// still taken in the cycle that the held result leaves.
// Reset (synchronous, active high) empties the list, clears the position count
// and sets the window length to one.
`timescale 1ns / 1ps

module sliding_window_maximum (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [swm_pkg::SAMPLE_W-1:0] req_sample,
   input  logic                                req_start_req,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [swm_pkg::SAMPLE_W-1:0] rsp_window_max,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [swm_pkg::WLEN_W-1:0]          csr_window_length
);

   logic [swm_pkg::WLEN_W-1:0]          wlen_ff;
   logic [swm_pkg::POS_W-1:0]           pos_ff;
   logic [swm_pkg::POS_W-1:0]           pos_in;
   logic                                full_ff;
   logic                                full_in;
   logic                                rsp_valid_ff;
   logic                                rsp_valid_in;
   logic signed [swm_pkg::SAMPLE_W-1:0] rsp_max_ff;
   logic signed [swm_pkg::SAMPLE_W-1:0] rsp_max_in;
   logic [swm_pkg::POS_W-1:0]           win;
   logic [swm_pkg::POS_W-1:0]           item_pos;
   logic                                out_free;
   logic                                accept;
   logic                                drain;
   swm_pkg::ctl_type                    ctl;
   swm_pkg::cell_type                   cell_data [swm_pkg::CELLS];
   swm_pkg::stat_type                   cell_stat [swm_pkg::CELLS];
   swm_pkg::cell_type                   nxt_data  [swm_pkg::CELLS];
   logic [swm_pkg::CELLS-1:0]           nxt_surv;
   logic [swm_pkg::CELLS-1:0]           prv_surv;
   logic [swm_pkg::CELLS-1:0]           cell_valid;

   assign csr_ready = 1'b1;

   // Clamp the window length into one to the cell count.
   always_comb begin
      if (wlen_ff == '0) begin
         win = swm_pkg::POS_W'(1);
      end else if (swm_pkg::POS_W'(wlen_ff) > swm_pkg::POS_W'(swm_pkg::CELLS)) begin
         win = swm_pkg::POS_W'(swm_pkg::CELLS);
      end else begin
         win = swm_pkg::POS_W'(wlen_ff);
      end
   end

   // Handshake: stall while the output is blocked or a second front entry must go first.
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !out_free || (!req_start_req && cell_stat[1].aged);
   assign accept    = req_valid && !req_stall;
   assign drain     = req_valid && !req_start_req && cell_stat[1].aged;
   assign item_pos  = req_start_req ? '0 : pos_ff;

   // Broadcast control to the chain.
   always_comb begin
      ctl.shift  = accept && !req_start_req && cell_stat[0].aged;
      ctl.start  = req_start_req;
      ctl.sample = req_sample;
      ctl.pos    = item_pos;
      ctl.win    = win;
      if (accept) begin
         ctl.op = swm_pkg::OP_ACCEPT;
      end else if (drain) begin
         ctl.op = swm_pkg::OP_DRAIN;
      end else begin
         ctl.op = swm_pkg::OP_HOLD;
      end
   end

   // Wire the cell chain.
   for (genvar i = 0; i < swm_pkg::CELLS; i++) begin : g_cell
      if (i == swm_pkg::CELLS - 1) begin : g_last
         assign nxt_data[i] = '0;
         assign nxt_surv[i] = 1'b0;
      end else begin : g_mid
         assign nxt_data[i] = cell_data[i+1];
         assign nxt_surv[i] = cell_stat[i+1].surv;
      end
      if (i == 0) begin : g_first
         assign prv_surv[i] = 1'b1;
      end else begin : g_rest
         assign prv_surv[i] = cell_stat[i-1].surv_sh;
      end
      assign cell_valid[i] = cell_data[i].valid;

      swm_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctl         (ctl),
         .nxt_data    (nxt_data[i]),
         .nxt_surv    (nxt_surv[i]),
         .prv_surv_sh (prv_surv[i]),
         .data        (cell_data[i]),
         .stat        (cell_stat[i])
      );
   end

   // Advance the position count and the window-full flag.
   always_comb begin
      pos_in  = pos_ff;
      full_in = full_ff;
      if (accept) begin
         pos_in  = item_pos + swm_pkg::POS_W'(1);
         full_in = (req_start_req ? 1'b0 : full_ff) ||
                   (({1'b0, item_pos} + (swm_pkg::POS_W+1)'(1)) >= {1'b0, win});
      end
   end

   // Select the new front of the list as the result.
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_max_in   = rsp_max_ff;
      if (accept) begin
         rsp_valid_in = full_in;
         if (cell_stat[0].surv) begin
            rsp_max_in = cell_data[0].value;
         end else if (cell_stat[1].surv) begin
            rsp_max_in = cell_data[1].value;
         end else begin
            rsp_max_in = req_sample;
         end
      end
   end

   // Hold control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         wlen_ff      <= swm_pkg::WLEN_W'(1);
         pos_ff       <= '0;
         full_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            wlen_ff <= csr_window_length;
         end
         pos_ff       <= pos_in;
         full_ff      <= full_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Hold the result payload.
   always_ff @(posedge clock) begin
      rsp_max_ff <= rsp_max_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_window_max = rsp_max_ff;

   // No item is taken while a second front entry is still out of the window.
   a_no_stale_accept: assert property (@(posedge clock) disable iff (reset)
      (accept && !req_start_req) |-> !cell_stat[1].aged)
      else $error("item taken with two aged front entries");

   // Occupied cells always form one block from the front.
   a_packed_list: assert property (@(posedge clock) disable iff (reset)
      (cell_valid[swm_pkg::CELLS-1:1] & ~cell_valid[swm_pkg::CELLS-2:0]) == '0)
      else $error("candidate list has a gap");

   // A restart leaves exactly one candidate and position one.
   a_restart: assert property (@(posedge clock) disable iff (reset)
      (accept && req_start_req) |=> (cell_valid == swm_pkg::CELLS'(1)) &&
                                    (pos_ff == swm_pkg::POS_W'(1)))
      else $error("restart did not reset the list");

   // A drain cycle with no result pending produces no result.
   a_drain_quiet: assert property (@(posedge clock) disable iff (reset)
      (drain && !accept && !rsp_valid_ff) |=> !rsp_valid_ff)
      else $error("result produced without an item");

endmodule
